/* sv/s2da_pkg.sv */
// Shared types and constants for the signed integer to decimal text block.
// No dependencies; imported by s2da_bcd_cell and signed_int_to_decimal_ascii.
`timescale 1ns / 1ps
`default_nettype none

package s2da_pkg;

  // Input word and decimal digit widths
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CHAR_W     = 6;

  // Counter widths for the bit loop and the digit loop
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS);

  localparam int RADIX = 10;

  // Double-dabble correction: add 3 to any digit of 5 or more before the shift
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(RADIX / 2);
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'((1 << (DIGIT_W - 1)) - RADIX / 2);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  // Control shared by every cell of the digit chain
  typedef struct packed {
    logic clear;      // zero the digit for a new request
    logic bit_shift;  // take one binary bit, correct and shift toward the top
    logic dig_shift;  // take the whole digit of the lower neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/s2da_bcd_cell.sv */
// One decimal digit of the double-dabble chain.
// Depends on s2da_pkg for the digit width, correction constants and control struct.
`timescale 1ns / 1ps
`default_nettype none

module s2da_bcd_cell import s2da_pkg::*; (
  input  wire                clk,
  input  wire  cell_ctrl_t   ctrl,
  input  wire                bit_in,
  output logic               bit_out,
  input  wire  [DIGIT_W-1:0] dig_in,
  output logic [DIGIT_W-1:0] dig
);

  logic [DIGIT_W-1:0] adj;

  // Correct the digit so that the shift carries into the next decade
  always_comb begin
    adj     = (dig >= ADJ_LIMIT) ? dig + ADJ_ADD : dig;
    bit_out = adj[DIGIT_W-1];
  end

  // Clear, shift in one bit, or take the neighbor's digit
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      dig <= '0;
    end else if (ctrl.bit_shift) begin
      dig <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      dig <= dig_in;
    end
  end

endmodule

`default_nettype wire

/* sv/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII text, one character per result.
// Depends on s2da_pkg and s2da_bcd_cell (a chain of ten digit cells).
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, value[31:0]  | request in
//   out     | out_valid, out_stall,            | request out
//           | char_code[5:0], is_last          |
//
// One request at a time: after the accept, the conversion shifts the magnitude
// through the cell chain one binary bit at a time, then a minus sign for a negative
// value is sent and the digit loop steps through the ten digit cells.
// Leading zeros pass through the chain without producing a character.
// Output stalls hold the output register and pause the sign and digit output; leading zeros are still skipped.
// rst is synchronous and clears the control state only.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii import s2da_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [VALUE_W-1:0] value,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [CHAR_W-1:0]  char_code,
  output logic               is_last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [VALUE_W-1:0]   mag;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DIG_CNT_W-1:0] dig_idx;
  logic                 neg;
  logic                 started;

  cell_ctrl_t           ctrl;
  logic [NUM_DIGITS:0]  carry;
  logic [DIGIT_W-1:0]   digs [NUM_DIGITS];
  logic [DIGIT_W-1:0]   top_dig;

  logic                 in_take;
  logic                 out_free;
  logic                 last_dig;
  logic                 skip_zero;
  logic                 emit_dig;
  logic                 emit_sign;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign top_dig   = digs[NUM_DIGITS-1];
  assign last_dig  = (dig_idx == DIG_CNT_W'(NUM_DIGITS - 1));
  assign skip_zero = (state == ST_EMIT) && !started && !last_dig && (top_dig == '0);
  assign emit_dig  = (state == ST_EMIT) && !skip_zero && out_free;
  assign emit_sign = (state == ST_SIGN) && out_free;

  // Drive the cell chain
  always_comb begin
    ctrl.clear     = in_take;
    ctrl.bit_shift = (state == ST_CONV);
    ctrl.dig_shift = skip_zero || emit_dig;
  end

  assign carry[0] = mag[VALUE_W-1];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
      s2da_bcd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (carry[gi]),
        .bit_out (carry[gi+1]),
        .dig_in  ((gi == 0) ? {DIGIT_W{1'b0}} : digs[(gi == 0) ? 0 : gi - 1]),
        .dig     (digs[gi])
      );
    end
  endgenerate

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_take) state_next = ST_CONV;
      ST_CONV: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: if (emit_sign) state_next = ST_EMIT;
      ST_EMIT: if (emit_dig && last_dig) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_sign || emit_dig) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Magnitude, counters and output payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      neg     <= value[VALUE_W-1];
      mag     <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bit_cnt <= '0;
    end else if (state == ST_CONV) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      dig_idx <= '0;
      started <= 1'b0;
    end
    if (skip_zero || emit_dig) begin
      dig_idx <= dig_idx + DIG_CNT_W'(1);
    end
    if (emit_dig) begin
      started <= 1'b1;
    end
    if (emit_sign) begin
      char_code <= CHAR_MINUS;
      is_last   <= 1'b0;
    end else if (emit_dig) begin
      char_code <= CHAR_ZERO + CHAR_W'(top_dig);
      is_last   <= last_dig;
    end
  end

  // Check the conversion flow and the emitted text
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_CONV) && (bit_cnt == '0))
    else $error("accepted request did not start conversion");

  a_conv_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) && (bit_cnt == BIT_CNT_W'(VALUE_W - 1))
      |=> (state == ST_SIGN) || (state == ST_EMIT))
    else $error("conversion did not end after the last bit");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top_dig < DIGIT_W'(RADIX)))
    else $error("digit out of decimal range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == CHAR_MINUS) |-> !is_last)
    else $error("minus sign flagged as last character");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for signed_int_to_decimal_ascii: drives integers, checks each character.
// Depends on s2da_pkg and the RTL top; a small class keeps the expected character stream.
`timescale 1ns / 1ps

module tb_top import s2da_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          RANDOM_PER_PHASE = 34;

  // Expected character stream, built from each accepted request
  class decimal_text_board;
    typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
    } text_char_t;

    text_char_t pending_chars[$];
    int error_count;
    int values_noted;
    int negatives_noted;
    int chars_checked;

    // Expand one accepted integer into its expected characters
    function void note_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] ten;
      logic [DIGIT_W-1:0] digits[$];
      text_char_t         c;
      ten = RADIX;
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      do begin
        digits.push_front(DIGIT_W'(mag % ten));
        mag = mag / ten;
      end while (mag != 0);
      if (v[VALUE_W-1]) begin
        c.code = CHAR_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
        negatives_noted++;
      end
      foreach (digits[i]) begin
        c.code = CHAR_ZERO + CHAR_W'(digits[i]);
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
      values_noted++;
    endfunction

    // Compare one delivered character with the oldest expectation
    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t exp_char;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $error("char_code: unexpected character %0d (is_last %0b) with nothing pending",
               code, last);
        error_count++;
        return;
      end
      exp_char = pending_chars.pop_front();
      if (code !== exp_char.code) begin
        $error("char_code mismatch: expected %0d, actual %0d", exp_char.code, code);
        error_count++;
      end
      if (last !== exp_char.last) begin
        $error("is_last mismatch: expected %0b, actual %0b", exp_char.last, last);
        error_count++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  char_code;
  logic               is_last;

  int          sender_idle_pct = 30;
  int          receiver_stall_pct = 69;
  int unsigned cycle_count = 0;

  decimal_text_board board = new;

  // Edge and corner values: zero, sign boundaries, digit-count boundaries
  logic [VALUE_W-1:0] directed_values[$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd5,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999999999, 32'd1000000000,
    -32'sd999999999, -32'sd1000000000, 32'd1000000009, 32'd1234567890,
    -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7
  };

  signed_int_to_decimal_ascii u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .is_last   (is_last)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d characters still pending",
               cycle_count, board.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check each accepted character and randomize the output stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_char(char_code, is_last);
    end
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Mix full-range words with shifted ones so every digit count shows up
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    if ($urandom_range(3) == 0) begin
      v = $urandom;
    end else begin
      v = $urandom >> $urandom_range(31);
      if ($urandom_range(1) == 1) begin
        v = -v;
      end
    end
    return v;
  endfunction

  // Offer one request, idling at random first, and hold it until accepted
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    board.note_value(v);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed corners under the first idle mix
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end

    // Random requests: sender light / receiver heavy, swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct    = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
      receiver_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
      repeat (RANDOM_PER_PHASE) begin
        send_value(random_value());
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray characters
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (%0d negative) into %0d checked characters",
             board.values_noted, board.negatives_noted, board.chars_checked);
    $display("Idle mixes: 30/69, 69/30 and 0/0 percent sender/receiver; %0d mismatches",
             board.error_count);
    if (board.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/s2da_pkg.sv
sv/s2da_bcd_cell.sv
sv/signed_int_to_decimal_ascii.sv
tb/tb_top.sv
